>>> rtl/mio_pkg.sv
// ----------------------------------------------------------------------------
// mio_pkg: shared types for the interval overlap block
// Beat payloads of the request and response channels and fixed field widths.
// ----------------------------------------------------------------------------
package mio_pkg;

   localparam int unsigned FieldTimeBits = 32;
   localparam int unsigned OverlapBits   = 11;
   localparam int unsigned OverlapSat    = 2047;

   typedef struct packed {
      logic [FieldTimeBits-1:0] arrival_time;
      logic [FieldTimeBits-1:0] departure_time;
      logic                     last_interval;
   } req_type;

   typedef struct packed {
      logic [OverlapBits-1:0] max_overlap;
      logic                   overflowed;
   } rsp_type;

endpackage

>>> rtl/mio_front.sv
// ----------------------------------------------------------------------------
// mio_front: interval intake
// Accepts interval beats, issues buffer writes, counts the set and posts a
// job descriptor when the last interval of a set arrives.
// ----------------------------------------------------------------------------
module mio_front
   import mio_pkg::*;
#(
   parameter int unsigned MAX_INTERVALS = 1024,
   parameter int unsigned TW            = 32,
   parameter int unsigned AW            = 10,
   parameter int unsigned NW            = 11
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  req_type       req_data,
   input  logic          busy,
   output logic          wr_en,
   output logic [AW-1:0] wr_addr,
   output logic [TW-1:0] wr_arr,
   output logic [TW-1:0] wr_dep,
   output logic          job_push,
   output logic [NW:0]   job_data
);

   logic          take;
   logic          room;
   logic [NW-1:0] cnt_ff, cnt_in, cnt_next;
   logic          ovf_ff, ovf_in, ovf_next;

   assign req_stall = busy;
   assign take      = req_valid && !busy;
   assign room      = cnt_ff < NW'(MAX_INTERVALS);

   // buffer write for a beat that still fits
   assign wr_en   = take && room;
   assign wr_addr = cnt_ff[AW-1:0];
   assign wr_arr  = req_data.arrival_time[TW-1:0];
   assign wr_dep  = req_data.departure_time[TW-1:0];

   // set bookkeeping
   always_comb begin
      cnt_next = room ? cnt_ff + NW'(1) : cnt_ff;
      ovf_next = ovf_ff || !room;
      cnt_in   = cnt_ff;
      ovf_in   = ovf_ff;
      job_push = 1'b0;
      if (take) begin
         if (req_data.last_interval) begin
            job_push = 1'b1;
            cnt_in   = '0;
            ovf_in   = 1'b0;
         end else begin
            cnt_in = cnt_next;
            ovf_in = ovf_next;
         end
      end
   end

   assign job_data = {ovf_next, cnt_next};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         ovf_ff <= ovf_in;
      end
   end

endmodule

>>> rtl/mio_queue.sv
// ----------------------------------------------------------------------------
// mio_queue: two-entry job queue
// Holds set descriptors between intake and sweep.
// ----------------------------------------------------------------------------
module mio_queue #(
   parameter int unsigned W = 12
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  logic [W-1:0] push_data,
   input  logic         pop,
   output logic [W-1:0] head,
   output logic         empty
);

   logic [W-1:0] slot_ff [2];
   logic [1:0]   fill_ff, fill_in;

   assign empty = fill_ff == 2'd0;
   assign head  = slot_ff[0];

   always_comb begin
      fill_in = fill_ff;
      if (push && !(pop && !empty) && fill_ff != 2'd2) fill_in = fill_ff + 2'd1;
      if (!push && pop && !empty) fill_in = fill_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   // payload shifts towards the head on a pop
   always_ff @(posedge clock) begin
      if (pop && !empty) begin
         slot_ff[0] <= (fill_ff == 2'd2) ? slot_ff[1] : push_data;
         if (push) slot_ff[1] <= push_data;
      end else if (push) begin
         if (fill_ff == 2'd0) slot_ff[0] <= push_data;
         else slot_ff[1] <= push_data;
      end
   end

endmodule

>>> rtl/mio_back.sv
// ----------------------------------------------------------------------------
// mio_back: overlap sweep engine
// Holds the event buffer. For each stored arrival it scans the set and counts
// arrivals minus departures at or before that time; the peak is reported.
// ----------------------------------------------------------------------------
module mio_back
   import mio_pkg::*;
#(
   parameter int unsigned MAX_INTERVALS = 1024,
   parameter int unsigned TW            = 32,
   parameter int unsigned AW            = 10,
   parameter int unsigned NW            = 11
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [TW-1:0] wr_arr,
   input  logic [TW-1:0] wr_dep,
   input  logic          job_valid,
   input  logic [NW:0]   job_data,
   output logic          job_pop,
   output logic          active,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_type       rsp_data
);

   localparam int unsigned CW = NW + 1;

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_TGET = 6'b000010,
      S_TCAP = 6'b000100,
      S_SCAN = 6'b001000,
      S_TAIL = 6'b010000,
      S_OUT  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic [TW-1:0] arr_mem [MAX_INTERVALS];
   logic [TW-1:0] dep_mem [MAX_INTERVALS];
   logic [TW-1:0] rd_arr_ff, rd_dep_ff, t_ff, t_in;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] i_ff, i_in, j_ff, j_in, last_ff, last_in;
   logic          pend_ff, pend_in;
   logic signed [CW-1:0] acc_ff, acc_in, best_ff, best_in, term, sum;
   logic          ovf_ff, ovf_in;
   logic [NW-1:0] job_n;

   // event buffer, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         arr_mem[wr_addr] <= wr_arr;
         dep_mem[wr_addr] <= wr_dep;
      end
      rd_arr_ff <= arr_mem[rd_addr];
      rd_dep_ff <= dep_mem[rd_addr];
   end

   assign rd_addr = (state_ff == S_SCAN) ? j_ff : i_ff;
   assign job_n   = job_data[NW-1:0];

   // contribution of one interval at the probe time
   always_comb begin
      term = '0;
      if (rd_arr_ff <= t_ff) term = term + CW'(1);
      if (rd_dep_ff <= t_ff) term = term - CW'(1);
      sum = acc_ff + term;
   end

   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      last_in  = last_ff;
      pend_in  = 1'b0;
      acc_in   = acc_ff;
      best_in  = best_ff;
      ovf_in   = ovf_ff;
      t_in     = t_ff;
      job_pop  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (job_valid) begin
               job_pop = 1'b1;
               ovf_in  = job_data[NW];
               best_in = '0;
               i_in    = '0;
               last_in = AW'(job_n - NW'(1));
               state_in = (job_n == '0) ? S_OUT : S_TGET;
            end
         end
         S_TGET: state_in = S_TCAP;
         S_TCAP: begin
            t_in     = rd_arr_ff;
            j_in     = '0;
            acc_in   = '0;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            pend_in = 1'b1;
            if (pend_ff) acc_in = sum;
            j_in = j_ff + AW'(1);
            if (j_ff == last_ff) state_in = S_TAIL;
         end
         S_TAIL: begin
            if (sum > best_ff) best_in = sum;
            i_in = i_ff + AW'(1);
            state_in = (i_ff == last_ff) ? S_OUT : S_TGET;
         end
         S_OUT: begin
            if (!rsp_stall) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff    <= i_in;
      j_ff    <= j_in;
      last_ff <= last_in;
      acc_ff  <= acc_in;
      best_ff <= best_in;
      ovf_ff  <= ovf_in;
      t_ff    <= t_in;
   end

   // result beat, saturated to the field width
   assign active    = state_ff != S_IDLE;
   assign rsp_valid = state_ff == S_OUT;
   always_comb begin
      rsp_data.overflowed = ovf_ff;
      if (CW > OverlapBits && best_ff > CW'(OverlapSat))
         rsp_data.max_overlap = OverlapBits'(OverlapSat);
      else
         rsp_data.max_overlap = OverlapBits'(best_ff);
   end

endmodule

>>> rtl/max_interval_overlap.sv
// Sweep: for a set of n intervals, each stored arrival takes a fetch, a capture, n scan
// reads and a tail step; the result beat is offered after the last arrival's tail step.
// Throughput: one interval beat per cycle while a set loads; the next set is
// held off until the current result beat has been taken.
// Reset: synchronous, active high; clears counts, queue and sweep control.
// ----------------------------------------------------------------------------
// max_interval_overlap: largest number of simultaneously open intervals
// Intake stores intervals, a job queue hands finished sets to the sweep.
// ----------------------------------------------------------------------------
module max_interval_overlap
   import mio_pkg::*;
#(
   parameter int unsigned MAX_INTERVALS = 1024,
   parameter int unsigned TIME_BITS     = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int unsigned TW = (TIME_BITS < FieldTimeBits) ? TIME_BITS : FieldTimeBits;
   localparam int unsigned AW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
   localparam int unsigned NW = $clog2(MAX_INTERVALS + 1) + 1;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [TW-1:0] wr_arr, wr_dep;
   logic          job_push, job_pop, q_empty, back_active;
   logic [NW:0]   job_data, job_head;

   // intake waits while a set is queued or being swept
   mio_front #(
      .MAX_INTERVALS(MAX_INTERVALS), .TW(TW), .AW(AW), .NW(NW)
   ) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .busy(!q_empty || back_active),
      .wr_en, .wr_addr, .wr_arr, .wr_dep, .job_push, .job_data
   );

   mio_queue #(.W(NW + 1)) u_queue (
      .clock, .reset, .push(job_push), .push_data(job_data),
      .pop(job_pop), .head(job_head), .empty(q_empty)
   );

   mio_back #(
      .MAX_INTERVALS(MAX_INTERVALS), .TW(TW), .AW(AW), .NW(NW)
   ) u_back (
      .clock, .reset, .wr_en, .wr_addr, .wr_arr, .wr_dep,
      .job_valid(!q_empty), .job_data(job_head), .job_pop,
      .active(back_active), .rsp_valid, .rsp_stall, .rsp_data
   );

endmodule
